FILE: hdl/u8u16_pkg.sv
package u8u16_pkg;

	// Width of the running UTF-16 offset counter
	localparam int OFFSET_BITS = 20;

	localparam logic [OFFSET_BITS:0] OFF_ONE = (OFFSET_BITS+1)'(1);
	localparam logic [OFFSET_BITS:0] OFF_TWO = (OFFSET_BITS+1)'(2);
	localparam logic [OFFSET_BITS:0] OFF_MAX =
		(OFFSET_BITS+1)'((64'd1 << OFFSET_BITS) - 64'd1);

	// Lead byte ranges
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	// Scalar limits
	localparam logic [20:0] MIN_LEN2  = 21'h80;
	localparam logic [20:0] MIN_LEN3  = 21'h800;
	localparam logic [20:0] MIN_LEN4  = 21'h10000;
	localparam logic [20:0] SURR_LO   = 21'hD800;
	localparam logic [20:0] SURR_HI   = 21'hDFFF;
	localparam logic [20:0] SCALAR_MAX = 21'h10FFFF;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

	typedef enum logic [1:0] {
		ST_UNIT      = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       text_last;
	} src_req_t;

	typedef struct packed {
		logic [15:0] utf16_unit;
		logic [20:0] scalar_value;
		logic [19:0] unit_offset;
		status_t     status;
		logic        run_last;
		logic        text_end;
	} res_req_t;

	typedef struct packed {
		logic [20:0]            partial;
		logic [1:0]             pending;
		logic [2:0]             seq_len;
		logic [OFFSET_BITS-1:0] offset;
		logic                   drop;
	} dec_state_t;

	// Fit the offset counter into the 20-bit result field
	function automatic logic [19:0] off_field(input logic [OFFSET_BITS-1:0] off);
		logic [OFFSET_BITS+19:0] ext;
		ext = {20'b0, off};
		return ext[19:0];
	endfunction

endpackage

FILE: hdl/u8u16_decode.sv
module u8u16_decode (
	input  u8u16_pkg::dec_state_t cur,
	input  u8u16_pkg::src_req_t   req,
	output u8u16_pkg::dec_state_t nxt,
	output u8u16_pkg::res_req_t   r0,
	output u8u16_pkg::res_req_t   r1,
	output logic [1:0]            n_res
);

	logic [7:0]                        b;
	logic                              last;
	logic [20:0]                       acc;
	logic [1:0]                        pend_m1;
	logic                              done;
	logic                              bad;
	logic [20:0]                       cp;
	logic                              is_pair;
	logic [20:0]                       sup;
	logic [u8u16_pkg::OFFSET_BITS:0]   end_off;
	logic [u8u16_pkg::OFFSET_BITS-1:0] off_p1;
	u8u16_pkg::dec_state_t             seq_nxt;

	assign b       = req.data_byte;
	assign last    = req.text_last;
	assign acc     = {cur.partial[14:0], b[5:0]};
	assign pend_m1 = cur.pending - 2'd1;
	assign off_p1  = cur.offset + {{(u8u16_pkg::OFFSET_BITS-1){1'b0}}, 1'b1};

	// Byte classification and scalar assembly
	always_comb begin
		seq_nxt = cur;
		done    = 1'b0;
		bad     = 1'b0;
		cp      = '0;
		if (!cur.drop) begin
			if (cur.pending == 2'd0) begin
				if (!b[7]) begin
					cp   = {13'b0, b};
					done = 1'b1;
				end else if (b >= u8u16_pkg::LEAD2_MIN && b <= u8u16_pkg::LEAD2_MAX) begin
					seq_nxt.partial = {16'b0, b[4:0]};
					seq_nxt.pending = 2'd1;
					seq_nxt.seq_len = 3'd2;
				end else if (b >= u8u16_pkg::LEAD3_MIN && b <= u8u16_pkg::LEAD3_MAX) begin
					seq_nxt.partial = {17'b0, b[3:0]};
					seq_nxt.pending = 2'd2;
					seq_nxt.seq_len = 3'd3;
				end else if (b >= u8u16_pkg::LEAD4_MIN && b <= u8u16_pkg::LEAD4_MAX) begin
					seq_nxt.partial = {18'b0, b[2:0]};
					seq_nxt.pending = 2'd3;
					seq_nxt.seq_len = 3'd4;
				end else begin
					bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				seq_nxt.partial = acc;
				seq_nxt.pending = pend_m1;
				if (pend_m1 == 2'd0) begin
					cp   = acc;
					done = 1'b1;
					// overlong, surrogate and range checks on the final byte
					if ((cur.seq_len == 3'd2 && acc < u8u16_pkg::MIN_LEN2) ||
					    (cur.seq_len == 3'd3 && acc < u8u16_pkg::MIN_LEN3) ||
					    (cur.seq_len == 3'd4 && acc < u8u16_pkg::MIN_LEN4) ||
					    (acc >= u8u16_pkg::SURR_LO && acc <= u8u16_pkg::SURR_HI) ||
					    acc > u8u16_pkg::SCALAR_MAX) begin
						bad  = 1'b1;
						done = 1'b0;
					end
				end
			end
			// text ends inside a sequence
			if (!bad && !done && last) begin
				bad = 1'b1;
			end
		end
	end

	assign is_pair = (cp[20:16] != 5'd0);
	assign sup     = cp - u8u16_pkg::MIN_LEN4;
	assign end_off = {1'b0, cur.offset} + (is_pair ? u8u16_pkg::OFF_TWO : u8u16_pkg::OFF_ONE);

	// Result formation, offset advance and end-of-text handling
	always_comb begin
		r0    = '0;
		r1    = '0;
		n_res = 2'd0;
		nxt   = seq_nxt;
		r0.unit_offset = u8u16_pkg::off_field(cur.offset);
		r0.status      = u8u16_pkg::ST_UNIT;
		r1.unit_offset = u8u16_pkg::off_field(off_p1);
		r1.status      = u8u16_pkg::ST_UNIT;
		if (cur.drop) begin
			if (last) begin
				nxt = '0;
			end
		end else if (bad) begin
			r0.status   = u8u16_pkg::ST_INVALID;
			r0.run_last = 1'b1;
			r0.text_end = 1'b1;
			n_res       = 2'd1;
			// drop the rest of the text
			nxt.partial = '0;
			nxt.pending = '0;
			nxt.seq_len = '0;
			nxt.drop    = 1'b1;
			if (last) begin
				nxt = '0;
			end
		end else if (done) begin
			nxt.partial = '0;
			nxt.pending = '0;
			nxt.seq_len = '0;
			if (end_off > u8u16_pkg::OFF_MAX) begin
				r0.status   = u8u16_pkg::ST_TOO_LARGE;
				r0.run_last = 1'b1;
				r0.text_end = 1'b1;
				n_res       = 2'd1;
				nxt.drop    = 1'b1;
			end else if (is_pair) begin
				r0.utf16_unit   = u8u16_pkg::HI_SURR_BASE + {6'b0, sup[19:10]};
				r0.scalar_value = cp;
				r1.utf16_unit   = u8u16_pkg::LO_SURR_BASE + {6'b0, sup[9:0]};
				r1.scalar_value = cp;
				r1.run_last     = 1'b1;
				r1.text_end     = last;
				n_res           = 2'd2;
				nxt.offset      = end_off[u8u16_pkg::OFFSET_BITS-1:0];
			end else begin
				r0.utf16_unit   = cp[15:0];
				r0.scalar_value = cp;
				r0.run_last     = 1'b1;
				r0.text_end     = last;
				n_res           = 2'd1;
				nxt.offset      = end_off[u8u16_pkg::OFFSET_BITS-1:0];
			end
			// next byte starts a new text at offset 0
			if (last) begin
				nxt = '0;
			end
		end
	end

endmodule

FILE: hdl/u8u16_fifo.sv
module u8u16_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  u8u16_pkg::res_req_t push0,
	input  u8u16_pkg::res_req_t push1,
	input  logic                pop,
	output logic                not_empty,
	output logic                room2,
	output u8u16_pkg::res_req_t head
);

	u8u16_pkg::res_req_t mem_q [4];
	logic [1:0]          wr_ptr_q;
	logic [1:0]          rd_ptr_q;
	logic [2:0]          count_q;
	logic [2:0]          count_after_pop;

	assign not_empty       = (count_q != 3'd0);
	assign count_after_pop = count_q - {2'b0, pop};
	// two free slots after this cycle's pop
	assign room2           = (count_after_pop <= 3'd2);
	assign head            = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_after_pop + {1'b0, push_n};
		end
	end

endmodule

FILE: hdl/utf8_to_utf16_decoder_core.sv
// Path: an accepted byte waits in the input stage, is decoded, and its results go to the
//   result queue. Throughput: one byte per cycle while the queue has room for two results;
//   the queue delivers one result per cycle, so a surrogate pair fits a four-byte sequence.
// Reset: arst_n clears the decode state, the input stage and the result queue at once;
//   src_stall is low out of reset, so the block accepts bytes once reset is released.
module utf8_to_utf16_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  u8u16_pkg::src_req_t src_data,
	output logic                res_valid,
	input  logic                res_stall,
	output u8u16_pkg::res_req_t res_data
);

	logic                  vld_s1;
	u8u16_pkg::src_req_t   req_s1;
	u8u16_pkg::dec_state_t state_q;
	u8u16_pkg::dec_state_t state_nxt;
	u8u16_pkg::res_req_t   r0;
	u8u16_pkg::res_req_t   r1;
	logic [1:0]            n_res;
	logic                  pop;
	logic                  room2;
	logic                  advance;
	logic [1:0]            push_n;

	assign pop       = res_valid && !res_stall;
	assign advance   = vld_s1 && room2;
	assign src_stall = vld_s1 && !room2;
	assign push_n    = advance ? n_res : 2'd0;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			req_s1 <= src_data;
		end
	end

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	u8u16_decode u_decode (
		.cur   (state_q),
		.req   (req_s1),
		.nxt   (state_nxt),
		.r0    (r0),
		.r1    (r1),
		.n_res (n_res)
	);

	u8u16_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (r0),
		.push1     (r1),
		.pop       (pop),
		.not_empty (res_valid),
		.room2     (room2),
		.head      (res_data)
	);

endmodule

FILE: tb/utf16_result_checker.sv
// Watches both channels of the UTF-8 to UTF-16 decoder, predicts the results
// of every accepted request and compares them in order against the block.
module utf16_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	input  logic                src_stall,
	input  u8u16_pkg::src_req_t src_data,
	input  logic                res_valid,
	input  logic                res_stall,
	input  u8u16_pkg::res_req_t res_data,
	output int                  fail_count,
	output int                  waiting,
	output int                  units_seen,
	output int                  invalid_seen,
	output int                  too_large_seen
);

	localparam longint POS_LIMIT = (longint'(1) << u8u16_pkg::OFFSET_BITS) - 1;
	localparam int     MAX_REPORTS = 100;

	// Decoder state as the predictor sees it
	logic [20:0]                       acc_scalar;
	logic [1:0]                        cont_left;
	logic [2:0]                        seq_bytes;
	logic [u8u16_pkg::OFFSET_BITS-1:0] utf16_pos;
	logic                              dropping;
	u8u16_pkg::res_req_t               expected_units[$];

	task automatic clear_seq();
		acc_scalar = '0;
		cont_left  = '0;
		seq_bytes  = '0;
	endtask

	task automatic clear_text();
		clear_seq();
		utf16_pos = '0;
		dropping  = 1'b0;
	endtask

	task automatic emit(input logic [15:0] unit, input logic [20:0] scalar,
			input logic [u8u16_pkg::OFFSET_BITS-1:0] pos, input u8u16_pkg::status_t st,
			input logic byte_done, input logic text_done);
		u8u16_pkg::res_req_t r;
		r.utf16_unit   = unit;
		r.scalar_value = scalar;
		r.unit_offset  = 20'(pos);
		r.status       = st;
		r.run_last     = byte_done;
		r.text_end     = text_done;
		expected_units = {expected_units, r};
	endtask

	// Predict the results of one byte and advance the state
	task automatic decode_byte(input u8u16_pkg::src_req_t req);
		logic [7:0]                        b;
		logic                              fin;
		logic                              bad;
		logic                              done;
		logic [20:0]                       cp;
		logic [19:0]                       sup;
		logic [u8u16_pkg::OFFSET_BITS-1:0] pos_next;
		int                                units;
		b    = req.data_byte;
		fin  = req.text_last;
		bad  = 1'b0;
		done = 1'b0;
		cp   = '0;

		if (dropping) begin
			if (fin)
				clear_text();
			return;
		end

		if (cont_left == 0) begin
			if (b < 8'h80) begin
				cp   = {13'd0, b};
				done = 1'b1;
			end else if (b >= u8u16_pkg::LEAD2_MIN && b <= u8u16_pkg::LEAD2_MAX) begin
				acc_scalar = {16'd0, b[4:0]};
				cont_left  = 2'd1;
				seq_bytes  = 3'd2;
			end else if (b >= u8u16_pkg::LEAD3_MIN && b <= u8u16_pkg::LEAD3_MAX) begin
				acc_scalar = {17'd0, b[3:0]};
				cont_left  = 2'd2;
				seq_bytes  = 3'd3;
			end else if (b >= u8u16_pkg::LEAD4_MIN && b <= u8u16_pkg::LEAD4_MAX) begin
				acc_scalar = {18'd0, b[2:0]};
				cont_left  = 2'd3;
				seq_bytes  = 3'd4;
			end else begin
				bad = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			bad = 1'b1;
		end else begin
			acc_scalar = {acc_scalar[14:0], b[5:0]};
			cont_left  = cont_left - 2'd1;
			if (cont_left == 0) begin
				cp   = acc_scalar;
				done = 1'b1;
				// overlong, surrogate and range checks on the final byte
				if ((seq_bytes == 3'd2 && cp < u8u16_pkg::MIN_LEN2) ||
						(seq_bytes == 3'd3 && cp < u8u16_pkg::MIN_LEN3) ||
						(seq_bytes == 3'd4 && cp < u8u16_pkg::MIN_LEN4) ||
						(cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI) ||
						cp > u8u16_pkg::SCALAR_MAX) begin
					bad  = 1'b1;
					done = 1'b0;
				end
			end
		end

		// text ends inside a sequence
		if (!bad && !done && fin)
			bad = 1'b1;

		if (bad) begin
			emit('0, '0, utf16_pos, u8u16_pkg::ST_INVALID, 1'b1, 1'b1);
			if (fin) begin
				clear_text();
			end else begin
				clear_seq();
				dropping = 1'b1;
			end
			return;
		end

		if (!done)
			return;

		units = (cp <= 21'hFFFF) ? 1 : 2;
		clear_seq();
		if (longint'(utf16_pos) + units > POS_LIMIT) begin
			emit('0, '0, utf16_pos, u8u16_pkg::ST_TOO_LARGE, 1'b1, 1'b1);
			if (fin)
				clear_text();
			else
				dropping = 1'b1;
			return;
		end

		if (units == 1) begin
			emit(cp[15:0], cp, utf16_pos, u8u16_pkg::ST_UNIT, 1'b1, fin);
		end else begin
			sup      = 20'(cp - u8u16_pkg::MIN_LEN4);
			pos_next = utf16_pos + 1'b1;
			emit(u8u16_pkg::HI_SURR_BASE + {6'd0, sup[19:10]}, cp, utf16_pos,
				u8u16_pkg::ST_UNIT, 1'b0, 1'b0);
			emit(u8u16_pkg::LO_SURR_BASE + {6'd0, sup[9:0]}, cp, pos_next,
				u8u16_pkg::ST_UNIT, 1'b1, fin);
		end
		utf16_pos = utf16_pos + u8u16_pkg::OFFSET_BITS'(units);
		if (fin)
			clear_text();
	endtask

	task automatic cmp_field(input string name, input logic [20:0] want,
			input logic [20:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Compare one delivered result with the oldest prediction
	task automatic check_result(input u8u16_pkg::res_req_t got);
		u8u16_pkg::res_req_t want;
		if (expected_units.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: result with nothing expected: expected none, got %h",
					$time, got);
			return;
		end
		want = expected_units.pop_front();
		case (want.status)
			u8u16_pkg::ST_UNIT:      units_seen++;
			u8u16_pkg::ST_INVALID:   invalid_seen++;
			u8u16_pkg::ST_TOO_LARGE: too_large_seen++;
			default:                 ;
		endcase
		cmp_field("utf16_unit", 21'(want.utf16_unit), 21'(got.utf16_unit));
		cmp_field("scalar_value", want.scalar_value, got.scalar_value);
		cmp_field("unit_offset", 21'(want.unit_offset), 21'(got.unit_offset));
		cmp_field("status", 21'(want.status), 21'(got.status));
		cmp_field("run_last", 21'(want.run_last), 21'(got.run_last));
		cmp_field("text_end", 21'(want.text_end), 21'(got.text_end));
	endtask

	// Delivered results are checked before the requests accepted at the same edge are predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_text();
			expected_units.delete();
		end else begin
			if (res_valid && !res_stall)
				check_result(res_data);
			if (src_valid && !src_stall)
				decode_byte(src_data);
		end
		waiting = expected_units.size();
	end

endmodule

FILE: tb/tb_utf8_to_utf16_decoder_core.sv
module tb_utf8_to_utf16_decoder_core;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 1000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	u8u16_pkg::src_req_t src_data  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	u8u16_pkg::res_req_t res_data;

	int fail_count;
	int waiting;
	int units_seen;
	int invalid_seen;
	int too_large_seen;

	// stimulus shaping
	bit   steady        = 1'b0;
	int   src_gap_odds  = 0;
	int   res_hold_odds = 0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;
	int   bytes_sent    = 0;
	int   texts_sent    = 0;
	logic [7:0] text_q[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	utf8_to_utf16_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	utf16_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.src_valid      (src_valid),
		.src_stall      (src_stall),
		.src_data       (src_data),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res_data       (res_data),
		.fail_count     (fail_count),
		.waiting        (waiting),
		.units_seen     (units_seen),
		.invalid_seen   (invalid_seen),
		.too_large_seen (too_large_seen)
	);

	// Result side back-pressure in random bursts
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!steady && res_hold_odds != 0 &&
				$urandom_range(1, res_hold_odds) == 1) begin
			hold_left <= $urandom_range(0, 12);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog: no request moved on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: watchdog: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Append one byte to the text under construction
	task automatic add_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endtask

	// Hand one byte over, with an optional idle burst in front of it
	task automatic push_byte(input logic [7:0] b, input logic fin);
		if (!steady && src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= '{data_byte: b, text_last: fin};
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			push_byte(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	// Hold the sender until every predicted result has been delivered
	task automatic drain_results();
		src_valid <= 1'b0;
		do
			@(negedge clk);
		while (waiting != 0);
		@(posedge clk);
	endtask

	function automatic int utf8_len(input logic [20:0] cp);
		if (cp < 21'h80)
			return 1;
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	// Encode with the given length; a longer one than needed gives an overlong form
	task automatic put_scalar(input logic [20:0] cp, input int len);
		case (len)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	function automatic logic [20:0] scalar_of_len(input int len);
		logic [20:0] cp;
		case (len)
			1: cp = 21'($urandom_range(0, 'h7F));
			2: cp = 21'($urandom_range('h80, 'h7FF));
			3: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				// move out of the surrogate block
				if (cp >= u8u16_pkg::SURR_LO && cp <= u8u16_pkg::SURR_HI)
					cp[12] = 1'b0;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		return cp;
	endfunction

	// Ordinary scalars half of the time, a boundary value the other half
	function automatic logic [20:0] any_scalar();
		case ($urandom_range(0, 19))
			0:  return 21'h0;
			1:  return 21'h7F;
			2:  return 21'h80;
			3:  return 21'h7FF;
			4:  return 21'h800;
			5:  return 21'hD7FF;
			6:  return 21'hE000;
			7:  return 21'hFFFF;
			8:  return 21'h10000;
			9:  return 21'h10FFFF;
			10, 11, 12, 13: return scalar_of_len(1);
			14, 15: return scalar_of_len(2);
			16, 17: return scalar_of_len(3);
			default: return scalar_of_len(4);
		endcase
	endfunction

	// One malformed piece; stop is set when the text has to end right after it
	task automatic put_fault(output bit stop);
		logic [7:0] b;
		int         len;
		stop = 1'b0;
		len  = $urandom_range(2, 4);
		case ($urandom_range(0, 5))
			0: begin
				// lead byte that no sequence may start with
				if ($urandom_range(0, 1))
					b = 8'($urandom_range('h80, 'hC1));
				else
					b = 8'($urandom_range('hF5, 'hFF));
				add_byte(b);
			end
			1: begin
				// sequence broken by a non-continuation byte
				put_scalar(scalar_of_len(len), len);
				repeat ($urandom_range(1, len - 1))
					void'(text_q.pop_back());
				b = 8'($urandom_range(0, 255));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				add_byte(b);
			end
			2: begin
				if ($urandom_range(0, 1))
					put_scalar(21'($urandom_range(0, 'hFFFF)), 4);
				else
					put_scalar(21'($urandom_range(0, 'h7FF)), 3);
			end
			3: put_scalar(21'($urandom_range('hD800, 'hDFFF)), 3);
			4: put_scalar(21'($urandom_range('h110000, 'h13FFFF)), 4);
			default: begin
				// text ends inside a sequence
				put_scalar(scalar_of_len(len), len);
				repeat ($urandom_range(1, len - 1))
					void'(text_q.pop_back());
				stop = 1'b1;
			end
		endcase
	endtask

	// Build a random text; live counts the bytes up to and including its fault, or all if none
	task automatic build_text(output int live);
		int          n_sc;
		int          mode;
		int          fault_at;
		bit          stop;
		logic [20:0] cp;
		text_q.delete();
		live = -1;
		n_sc = $urandom_range(1, 10);
		mode = $urandom_range(0, 9);
		if (mode == 9) begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom_range(0, 255)));
			live = text_q.size();
			return;
		end
		fault_at = (mode >= 7) ? $urandom_range(0, n_sc - 1) : -1;
		for (int i = 0; i < n_sc; i++) begin
			if (i == fault_at) begin
				put_fault(stop);
				live = text_q.size();
				if (stop)
					break;
			end else begin
				cp = any_scalar();
				put_scalar(cp, utf8_len(cp));
			end
		end
		if (live < 0)
			live = text_q.size();
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 3;
			2:       return 8;
			default: return 20;
		endcase
	endfunction

	initial begin
		int live;
		int sent_rand;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, boundary scalars and each kind of malformed input
		src_gap_odds  = 4;
		res_hold_odds = 4;
		text_q = {8'h00, 8'h7F};
		send_text();
		text_q = {8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text();
		text_q = {8'hC0, 8'h41, 8'h42};
		send_text();
		text_q = {8'hED, 8'hA0, 8'h80};
		send_text();
		text_q = {8'hF4, 8'h90, 8'h80, 8'h80};
		send_text();
		text_q = {8'hE0, 8'h80, 8'h80};
		send_text();
		text_q = {8'hE2, 8'h82};
		send_text();
		text_q = {8'hC2, 8'h41};
		send_text();
		text_q = {8'hFF};
		send_text();
		drain_results();

		// Random texts, mostly well formed
		sent_rand = 0;
		while (sent_rand < RANDOM_BYTES) begin
			if (sent_rand >= RANDOM_BYTES * 85 / 100) begin
				steady = 1'b1;
			end else begin
				src_gap_odds  = pick_odds();
				res_hold_odds = pick_odds();
			end
			build_text(live);
			send_text();
			sent_rand += live;
			if (texts_sent % 40 == 0)
				drain_results();
		end

		src_valid <= 1'b0;
		do
			@(negedge clk);
		while (waiting != 0);
		repeat (20) @(posedge clk);
		@(negedge clk);

		$display("Run: %0d bytes in %0d texts, well formed and malformed, with random stalls",
			bytes_sent, texts_sent);
		$display("Results checked: %0d units, %0d invalid, %0d too large",
			units_seen, invalid_seen, too_large_seen);
		if (fail_count == 0 && waiting == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
